[src/usv_pkg.sv]
// usv_pkg: byte classes, queue word layout and code point limits shared by
// the UTF-8 source validator modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package usv_pkg;

    typedef enum logic [3:0] {
        CL_NUL,
        CL_LF,
        CL_CR,
        CL_ASCII,
        CL_CONT,
        CL_LEAD2,
        CL_LEAD3,
        CL_LEAD4,
        CL_BAD
    } byte_class_t;

    // One classified word as it travels from the front end to the engine
    typedef struct packed {
        byte_class_t cls;
        logic [7:0]  data;
        logic        last;
    } q_entry_t;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NUL  = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    localparam logic [2:0] SEQ_LEN2 = 3'd2;
    localparam logic [2:0] SEQ_LEN3 = 3'd3;
    localparam logic [2:0] SEQ_LEN4 = 3'd4;

    localparam logic [20:0] CP_MIN2 = 21'h000080;
    localparam logic [20:0] CP_MIN3 = 21'h000800;
    localparam logic [20:0] CP_MIN4 = 21'h010000;
    localparam logic [20:0] CP_MAX  = 21'h10FFFF;
    localparam logic [20:0] SURR_LO = 21'h00D800;
    localparam logic [20:0] SURR_HI = 21'h00DFFF;

    localparam int unsigned QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

[src/utf8_source_validator.sv]
// utf8_source_validator: top level; classifier front end, word queue and
// decode engine. Depends on usv_pkg, usv_classify, usv_queue, usv_engine.
//
//  channel  | direction | tdata                                  | tlast
//  s_axis   | in        | [7:0] text_byte                        | final_byte
//  m_axis   | out       | failed, fault_kind, fault_line, column | -
//
// One byte per clock unless a final byte waits; a byte is queued before the engine
// sees it, and a final byte's verdict is visible the cycle after the engine takes it.
// The two-entry queue lets the front accept while the engine waits on m_axis_tready.
// Only a final byte waits for the output register; other bytes pass a stalled verdict.
// Reset is synchronous on aresetn low and returns line and column to 1.
`timescale 1ns / 1ps
`default_nettype none

module utf8_source_validator #(
    parameter int POSITION_BITS = 24
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [7:0]                        s_axis_tdata,  // [7:0] text_byte
    input  wire logic                              s_axis_tlast,  // final_byte
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // failed, fault_kind[1:0], fault_line, fault_column, zero pad
    output logic [((2*POSITION_BITS+3+7)/8)*8-1:0] m_axis_tdata
);
    import usv_pkg::*;

    localparam int OUT_W = ((2*POSITION_BITS + 3 + 7) / 8) * 8;

    q_entry_t                 front_item, back_item;
    logic                     back_valid, back_ready;
    logic                     res_failed;
    logic [1:0]               res_kind;
    logic [POSITION_BITS-1:0] res_line, res_col;

    usv_classify u_classify (
        .text_byte  (s_axis_tdata),
        .final_byte (s_axis_tlast),
        .entry      (front_item)
    );

    usv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_axis_tvalid),
        .wr_ready (s_axis_tready),
        .wr_item  (front_item),
        .rd_valid (back_valid),
        .rd_ready (back_ready),
        .rd_item  (back_item)
    );

    usv_engine #(
        .POSITION_BITS (POSITION_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (back_valid),
        .in_ready   (back_ready),
        .in_item    (back_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_failed (res_failed),
        .out_kind   (res_kind),
        .out_line   (res_line),
        .out_column (res_col)
    );

    assign m_axis_tdata = OUT_W'({res_col, res_line, res_kind, res_failed});

endmodule

`default_nettype wire

[src/usv_classify.sv]
// usv_classify: front end; sorts each incoming byte into its UTF-8 class.
// Depends on usv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usv_classify (
    input  wire logic [7:0]        text_byte,
    input  wire logic              final_byte,
    output usv_pkg::q_entry_t      entry
);
    import usv_pkg::*;

    byte_class_t cls;

    always_comb begin
        case (text_byte) inside
            8'h00:          cls = CL_NUL;
            8'h0A:          cls = CL_LF;
            8'h0D:          cls = CL_CR;
            [8'h01:8'h7F]:  cls = CL_ASCII;
            [8'h80:8'hBF]:  cls = CL_CONT;
            [8'hC0:8'hDF]:  cls = CL_LEAD2;
            [8'hE0:8'hEF]:  cls = CL_LEAD3;
            [8'hF0:8'hF4]:  cls = CL_LEAD4;
            default:        cls = CL_BAD;
        endcase
    end

    assign entry.cls  = cls;
    assign entry.data = text_byte;
    assign entry.last = final_byte;

endmodule

`default_nettype wire

[src/usv_queue.sv]
// usv_queue: short queue of classified words between front end and engine.
// Depends on usv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usv_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  wire usv_pkg::q_entry_t wr_item,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output usv_pkg::q_entry_t      rd_item
);
    import usv_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    q_entry_t           slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               push, pop;

    assign wr_ready = (count_reg != FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

[src/usv_engine.sv]
// usv_engine: back end; decodes sequences, tracks line and column, latches
// the first fault and holds the verdict in an output register. Depends on usv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module usv_engine #(
    parameter int POSITION_BITS = 24
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire usv_pkg::q_entry_t         in_item,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           out_failed,
    output logic [1:0]                     out_kind,
    output logic [POSITION_BITS-1:0]       out_line,
    output logic [POSITION_BITS-1:0]       out_column
);
    import usv_pkg::*;

    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (&v) ? v : v + POS_ONE;
    endfunction

    logic [1:0]               owed_reg, owed_next;
    logic [20:0]              code_reg, code_next;
    logic [2:0]               len_reg, len_next;
    logic                     cr_reg, cr_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic                     seen_reg, seen_next;
    logic [1:0]               kind_reg, kind_next;
    logic [POSITION_BITS-1:0] fline_reg, fline_next;
    logic [POSITION_BITS-1:0] fcol_reg, fcol_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     res_failed;
    logic [1:0]               res_kind;
    logic [POSITION_BITS-1:0] res_line, res_col;

    logic                     pop, emit, bad, after_cr;
    logic [20:0]              code_acc;
    logic [POSITION_BITS-1:0] col_base;

    assign pop      = in_valid && in_ready;
    assign in_ready = !in_item.last || !out_valid_reg || out_ready;
    assign emit     = pop && in_item.last;

    always_comb begin
        owed_next  = owed_reg;
        code_next  = code_reg;
        len_next   = len_reg;
        cr_next    = cr_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        seen_next  = seen_reg;
        kind_next  = kind_reg;
        fline_next = fline_reg;
        fcol_next  = fcol_reg;
        code_acc   = {code_reg[14:0], in_item.data[5:0]};
        col_base   = cr_reg ? sat_inc(col_reg) : col_reg;
        bad        = 1'b0;
        after_cr   = 1'b0;

        if (pop && !seen_reg) begin
            if (owed_reg != 2'd0) begin
                if (in_item.cls != CL_CONT) begin
                    seen_next  = 1'b1;
                    kind_next  = KIND_BAD;
                    fline_next = line_reg;
                    fcol_next  = col_reg;
                end else begin
                    code_next = code_acc;
                    owed_next = owed_reg - 2'd1;
                    if (owed_reg == 2'd1) begin
                        case (len_reg)
                            SEQ_LEN2: bad = (code_acc < CP_MIN2);
                            SEQ_LEN3: bad = (code_acc < CP_MIN3) ||
                                            (code_acc >= SURR_LO && code_acc <= SURR_HI);
                            default:  bad = (code_acc < CP_MIN4) || (code_acc > CP_MAX);
                        endcase
                        if (bad) begin
                            seen_next  = 1'b1;
                            kind_next  = KIND_BAD;
                            fline_next = line_reg;
                            fcol_next  = col_reg;
                        end else begin
                            code_next = '0;
                            len_next  = '0;
                            col_next  = sat_inc(col_reg);
                        end
                    end
                end
            end else begin
                // CR waits one word to see whether LF follows
                if (cr_reg) begin
                    cr_next = 1'b0;
                    if (in_item.cls == CL_LF) begin
                        after_cr  = 1'b1;
                        line_next = sat_inc(line_reg);
                        col_next  = POS_ONE;
                    end
                end
                if (!after_cr) begin
                    col_next = col_base;
                    case (in_item.cls)
                        CL_NUL: begin
                            seen_next  = 1'b1;
                            kind_next  = KIND_NUL;
                            fline_next = line_reg;
                            fcol_next  = col_base;
                        end
                        CL_CR: begin
                            cr_next = 1'b1;
                        end
                        CL_LF: begin
                            line_next = sat_inc(line_reg);
                            col_next  = POS_ONE;
                        end
                        CL_ASCII: begin
                            col_next = sat_inc(col_base);
                        end
                        CL_LEAD2: begin
                            owed_next = 2'd1;
                            len_next  = SEQ_LEN2;
                            code_next = {16'd0, in_item.data[4:0]};
                        end
                        CL_LEAD3: begin
                            owed_next = 2'd2;
                            len_next  = SEQ_LEN3;
                            code_next = {17'd0, in_item.data[3:0]};
                        end
                        CL_LEAD4: begin
                            owed_next = 2'd3;
                            len_next  = SEQ_LEN4;
                            code_next = {18'd0, in_item.data[2:0]};
                        end
                        default: begin
                            seen_next  = 1'b1;
                            kind_next  = KIND_BAD;
                            fline_next = line_reg;
                            fcol_next  = col_base;
                        end
                    endcase
                end
            end
        end

        // Verdict: a sequence still open at the last word is a fault at its lead byte
        if (!seen_next && owed_next != 2'd0) begin
            res_failed = 1'b1;
            res_kind   = KIND_BAD;
            res_line   = line_next;
            res_col    = col_next;
        end else begin
            res_failed = seen_next;
            res_kind   = kind_next;
            res_line   = fline_next;
            res_col    = fcol_next;
        end

        if (emit) begin
            owed_next  = '0;
            code_next  = '0;
            len_next   = '0;
            cr_next    = 1'b0;
            line_next  = POS_ONE;
            col_next   = POS_ONE;
            seen_next  = 1'b0;
            kind_next  = KIND_NONE;
            fline_next = '0;
            fcol_next  = '0;
        end

        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owed_reg      <= '0;
            code_reg      <= '0;
            len_reg       <= '0;
            cr_reg        <= 1'b0;
            line_reg      <= POS_ONE;
            col_reg       <= POS_ONE;
            seen_reg      <= 1'b0;
            kind_reg      <= KIND_NONE;
            fline_reg     <= '0;
            fcol_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            owed_reg      <= owed_next;
            code_reg      <= code_next;
            len_reg       <= len_next;
            cr_reg        <= cr_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            seen_reg      <= seen_next;
            kind_reg      <= kind_next;
            fline_reg     <= fline_next;
            fcol_reg      <= fcol_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_failed <= res_failed;
            out_kind   <= res_kind;
            out_line   <= res_line;
            out_column <= res_col;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[src/usv_checker.sv]
// usv_checker: port-level checks on the validator's verdict channel, bound
// to utf8_source_validator. Depends on usv_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module usv_checker #(
    parameter int POSITION_BITS = 24
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [((2*POSITION_BITS+3+7)/8)*8-1:0] m_axis_tdata
);
    import usv_pkg::*;

    localparam int KIND_LO = 1;
    localparam int LINE_LO = 3;
    localparam int COL_LO  = 3 + POSITION_BITS;

    logic                     v_failed;
    logic [1:0]               v_kind;
    logic [POSITION_BITS-1:0] v_line, v_col;

    assign v_failed = m_axis_tdata[0];
    assign v_kind   = m_axis_tdata[KIND_LO +: 2];
    assign v_line   = m_axis_tdata[LINE_LO +: POSITION_BITS];
    assign v_col    = m_axis_tdata[COL_LO +: POSITION_BITS];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict dropped or changed under stall");

    a_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !v_failed |-> v_kind == KIND_NONE && v_line == '0 && v_col == '0)
        else $error("passing verdict carries fault data");

    a_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && v_failed |->
            (v_kind == KIND_NUL || v_kind == KIND_BAD) && v_line != '0 && v_col != '0)
        else $error("failing verdict lacks kind or position");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("verdict valid after reset");

endmodule

bind utf8_source_validator usv_checker #(
    .POSITION_BITS (POSITION_BITS)
) u_usv_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
